// ===== rtl/bxd_pkg.sv =====
// Shared constants, types and the reciprocal table of the box average decimator.
// No dependencies; the interface, lane, merge and top-level files import it.
`default_nettype none

package bxd_pkg;

	localparam int MAX_WIDTH  = 2048;
	localparam int MAX_HEIGHT = 4096;

	localparam int COL_W  = $clog2(MAX_WIDTH);
	localparam int ROW_W  = $clog2(MAX_HEIGHT);
	localparam int WEFF_W = COL_W + 1;
	localparam int HEFF_W = ROW_W + 1;

	localparam int WCFG_W = 12;
	localparam int HCFG_W = 13;
	localparam int FCFG_W = 7;
	localparam int CFG_DW = 13;
	localparam int CFG_IW = 2;

	localparam logic [CFG_IW-1:0] REG_IMAGE_WIDTH  = 2'd0;
	localparam logic [CFG_IW-1:0] REG_IMAGE_HEIGHT = 2'd1;
	localparam logic [CFG_IW-1:0] REG_DECIMATION   = 2'd2;

	localparam logic [WCFG_W-1:0] RST_WIDTH  = 12'd640;
	localparam logic [HCFG_W-1:0] RST_HEIGHT = 13'd480;
	localparam logic [FCFG_W-1:0] RST_FACTOR = 7'd1;

	localparam int CH_W   = 8;
	localparam int PIX_W  = 3 * CH_W;
	localparam int SUM_W  = 12;
	localparam int CNT_W  = 4;
	localparam int RCP_W  = 17;
	localparam int RCP_SH = 16;
	localparam int LANES  = 4;
	localparam int SEL_W  = $clog2(LANES);

	typedef logic [PIX_W-1:0] bxd_pix_t;
	typedef logic [2:0][2:0][PIX_W-1:0] bxd_win_t;

	typedef struct packed {
		logic [2:0]       colm;
		logic [2:0]       rowm;
		logic [CNT_W-1:0] cnt;
		logic [COL_W-1:0] ocol;
		logic [ROW_W-1:0] orow;
	} bxd_cand_t;

	typedef struct packed {
		logic [CH_W-1:0]  red;
		logic [CH_W-1:0]  green;
		logic [CH_W-1:0]  blue;
		logic [COL_W-1:0] col;
		logic [ROW_W-1:0] row;
	} bxd_res_t;

	typedef struct packed {
		logic     vld;
		bxd_res_t res;
	} bxd_lane_out_t;

	function automatic logic [RCP_W-1:0] recip(input logic [CNT_W-1:0] n);
		logic [RCP_W-1:0] r;
		case (n)
			4'd1: r = 17'd65536;
			4'd2: r = 17'd32768;
			4'd3: r = 17'd21846;
			4'd4: r = 17'd16384;
			4'd5: r = 17'd13108;
			4'd6: r = 17'd10923;
			4'd7: r = 17'd9363;
			4'd8: r = 17'd8192;
			4'd9: r = 17'd7282;
			default: r = 17'd65536;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/bxd_if.sv =====
// Valid/ready channel interfaces for pixels in and averaged results out.
// Depends on bxd_pkg for field widths.
`default_nettype none

interface bxd_pix_if import bxd_pkg::*; ();
	logic            valid;
	logic            ready;
	logic [CH_W-1:0] pixel_red;
	logic [CH_W-1:0] pixel_green;
	logic [CH_W-1:0] pixel_blue;

	modport source (output valid, output pixel_red, output pixel_green, output pixel_blue,
		input ready);
	modport sink (input valid, input pixel_red, input pixel_green, input pixel_blue,
		output ready);
endinterface

interface bxd_res_if import bxd_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [CH_W-1:0]  avg_red;
	logic [CH_W-1:0]  avg_green;
	logic [CH_W-1:0]  avg_blue;
	logic [COL_W-1:0] out_col;
	logic [ROW_W-1:0] out_row;
	logic             last_of_run;

	modport source (output valid, output avg_red, output avg_green, output avg_blue,
		output out_col, output out_row, output last_of_run, input ready);
	modport sink (input valid, input avg_red, input avg_green, input avg_blue,
		input out_col, input out_row, input last_of_run, output ready);
endinterface

`default_nettype wire

// ===== rtl/bxd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module bxd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/bxd_lane.sv =====
// One averaging lane: masked 3x3 channel sums, then division by the neighbor count.
// Depends on bxd_pkg for the candidate and result types and the reciprocal table.
`default_nettype none

module bxd_lane import bxd_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          adv,
	input  logic          vld,
	input  bxd_cand_t     cand,
	input  bxd_win_t      win,
	output bxd_lane_out_t lane_out
);

	logic [SUM_W-1:0] sr, sg, sb;
	logic [SUM_W-1:0] sr_s3, sg_s3, sb_s3;
	logic [CNT_W-1:0] cnt_s3;
	logic [COL_W-1:0] col_s3;
	logic [ROW_W-1:0] row_s3;
	logic             vld_s3;
	logic [RCP_W-1:0] rcp;
	logic [SUM_W+RCP_W-1:0] pr, pg, pb;

	always_comb begin
		sr = '0;
		sg = '0;
		sb = '0;
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				if (cand.colm[i] && cand.rowm[j]) begin
					sr = sr + SUM_W'(win[i][j][2*CH_W +: CH_W]);
					sg = sg + SUM_W'(win[i][j][CH_W +: CH_W]);
					sb = sb + SUM_W'(win[i][j][0 +: CH_W]);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (adv) begin
			vld_s3 <= vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sr_s3  <= sr;
			sg_s3  <= sg;
			sb_s3  <= sb;
			cnt_s3 <= cand.cnt;
			col_s3 <= cand.ocol;
			row_s3 <= cand.orow;
		end
	end

	assign rcp = recip(cnt_s3);
	assign pr  = (SUM_W+RCP_W)'(sr_s3) * (SUM_W+RCP_W)'(rcp);
	assign pg  = (SUM_W+RCP_W)'(sg_s3) * (SUM_W+RCP_W)'(rcp);
	assign pb  = (SUM_W+RCP_W)'(sb_s3) * (SUM_W+RCP_W)'(rcp);

	assign lane_out.vld       = vld_s3;
	assign lane_out.res.red   = pr[RCP_SH +: CH_W];
	assign lane_out.res.green = pg[RCP_SH +: CH_W];
	assign lane_out.res.blue  = pb[RCP_SH +: CH_W];
	assign lane_out.res.col   = col_s3;
	assign lane_out.res.row   = row_s3;

endmodule

`default_nettype wire

// ===== rtl/bxd_merge.sv =====
// Result bundle register: captures the four lanes and hands their results out in order.
// Depends on bxd_pkg and the result channel interface.
`default_nettype none

module bxd_merge import bxd_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  bxd_lane_out_t lane_in [LANES],
	output logic          adv,
	bxd_res_if.source     res
);

	logic [LANES-1:0] pend_q;
	bxd_res_t         bund_q [LANES];
	logic [SEL_W-1:0] sel;
	logic [LANES-1:0] sel_oh;
	logic             xfer;

	always_comb begin
		sel    = '0;
		sel_oh = '0;
		for (int k = LANES - 1; k >= 0; k--) begin
			if (pend_q[k]) begin
				sel    = SEL_W'(k);
				sel_oh = LANES'(1) << k;
			end
		end
	end

	assign xfer = res.valid && res.ready;
	assign adv  = (pend_q == '0) || ($onehot(pend_q) && res.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (adv) begin
			for (int k = 0; k < LANES; k++) begin
				pend_q[k] <= lane_in[k].vld;
			end
		end else if (xfer) begin
			pend_q <= pend_q & ~sel_oh;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < LANES; k++) begin
				bund_q[k] <= lane_in[k].res;
			end
		end
	end

	assign res.valid       = pend_q != '0;
	assign res.avg_red     = bund_q[sel].red;
	assign res.avg_green   = bund_q[sel].green;
	assign res.avg_blue    = bund_q[sel].blue;
	assign res.out_col     = bund_q[sel].col;
	assign res.out_row     = bund_q[sel].row;
	assign res.last_of_run = (pend_q & ~sel_oh) == '0;

	a_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.ready && !res.last_of_run |=> res.valid)
		else $error("result run broke off before its last transfer");

endmodule

`default_nettype wire

// ===== rtl/box_average_decimator.sv =====
// Top level of the box average decimator: counters, line stores, window, lanes, merge.
// Depends on bxd_pkg, bxd_if, bxd_ram, bxd_lane and bxd_merge.
//
// Pixels arrive in row order, one per transfer; the block takes one pixel every clock while
// the output keeps up. A pixel that completes k sampled centres (k up to four, in the last
// column and row) stalls the input until k - 1 of its results have left, as the bundle
// register of the four lanes hands out one result per cycle, while the output is ready, on
// the single output port. A result passes the line store read, window, lane sum and divide
// into the bundle. The two line stores need no clearing pass after reset: entries never
// written only feed neighbors outside the image. Any register write restarts the frame at
// column 0, row 0; write registers only while no pixel is in flight.
`default_nettype none

module box_average_decimator import bxd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wen,
	input  logic [CFG_IW-1:0] cfg_idx,
	input  logic [CFG_DW-1:0] cfg_wdata,
	bxd_pix_if.sink           pix,
	bxd_res_if.source         res
);

	logic [WCFG_W-1:0] w_q;
	logic [HCFG_W-1:0] h_q;
	logic [FCFG_W-1:0] f_q;
	logic [WEFF_W-1:0] w_eff;
	logic [HEFF_W-1:0] h_eff;
	logic [FCFG_W-1:0] f_eff, f_last;
	logic              cfg_hit;

	logic [COL_W-1:0]  col_q, cquo_q, pcq_q;
	logic [ROW_W-1:0]  row_q, rquo_q, prq_q;
	logic [FCFG_W-1:0] cmod_q, rmod_q;
	logic              pcz_q, prz_q;
	logic              col_last, row_last, col_ge1, col_ge2, row_ge1, row_ge2;

	logic              advance, acc;
	logic              lane_merge_adv;
	logic [LANES-1:0]  cv;
	bxd_cand_t         cand [LANES];

	logic              s1_valid_q;
	logic [LANES-1:0]  cv_s1, cv_s2;
	bxd_cand_t         cand_s1 [LANES];
	bxd_cand_t         cand_s2 [LANES];
	bxd_pix_t          pix_s1, fup_s1, fmid_s1;
	logic [COL_W-1:0]  col_s1;
	logic              byp_s1;
	bxd_pix_t          up_rd, mid_rd, up_eff, mid_eff;
	bxd_win_t          win_q;
	bxd_lane_out_t     lane_out [LANES];

	assign cfg_hit = cfg_wen && (cfg_idx == REG_IMAGE_WIDTH || cfg_idx == REG_IMAGE_HEIGHT ||
		cfg_idx == REG_DECIMATION);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q <= RST_WIDTH;
			h_q <= RST_HEIGHT;
			f_q <= RST_FACTOR;
		end else if (cfg_wen) begin
			case (cfg_idx)
				REG_IMAGE_WIDTH:  w_q <= cfg_wdata[WCFG_W-1:0];
				REG_IMAGE_HEIGHT: h_q <= cfg_wdata[HCFG_W-1:0];
				REG_DECIMATION:   f_q <= cfg_wdata[FCFG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (w_q == '0) begin
			w_eff = WEFF_W'(1);
		end else if (w_q > MAX_WIDTH) begin
			w_eff = WEFF_W'(MAX_WIDTH);
		end else begin
			w_eff = WEFF_W'(w_q);
		end
		if (h_q == '0) begin
			h_eff = HEFF_W'(1);
		end else if (h_q > MAX_HEIGHT) begin
			h_eff = HEFF_W'(MAX_HEIGHT);
		end else begin
			h_eff = HEFF_W'(h_q);
		end
	end

	assign f_eff  = (f_q == '0) ? FCFG_W'(1) : f_q;
	assign f_last = f_eff - FCFG_W'(1);

	assign col_last = WEFF_W'(col_q) == w_eff - WEFF_W'(1);
	assign row_last = HEFF_W'(row_q) == h_eff - HEFF_W'(1);
	assign col_ge1  = col_q != '0;
	assign col_ge2  = (col_q != '0) && (col_q != COL_W'(1));
	assign row_ge1  = row_q != '0;
	assign row_ge2  = (row_q != '0) && (row_q != ROW_W'(1));

	assign advance   = lane_merge_adv;
	assign pix.ready = advance;
	assign acc       = pix.valid && advance;

	always_comb begin
		logic [1:0] nc, nr;
		nc = '0;
		nr = '0;
		for (int k = 0; k < LANES; k++) begin
			if (k[0]) begin
				cand[k].colm = {1'b1, col_ge1, 1'b0};
				cand[k].ocol = cquo_q;
			end else begin
				cand[k].colm = {1'b1, 1'b1, col_ge2};
				cand[k].ocol = pcq_q;
			end
			if (k[1]) begin
				cand[k].rowm = {1'b1, row_ge1, 1'b0};
				cand[k].orow = rquo_q;
			end else begin
				cand[k].rowm = {1'b1, 1'b1, row_ge2};
				cand[k].orow = prq_q;
			end
			nc = 2'($countones(cand[k].colm));
			nr = 2'($countones(cand[k].rowm));
			cand[k].cnt = CNT_W'(nc) * CNT_W'(nr);
			cv[k] = (k[0] ? (col_last && cmod_q == '0) : (col_ge1 && pcz_q)) &&
				(k[1] ? (row_last && rmod_q == '0) : (row_ge1 && prz_q));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			cmod_q <= '0;
			cquo_q <= '0;
			pcz_q  <= 1'b0;
			pcq_q  <= '0;
			row_q  <= '0;
			rmod_q <= '0;
			rquo_q <= '0;
			prz_q  <= 1'b0;
			prq_q  <= '0;
		end else if (cfg_hit) begin
			col_q  <= '0;
			cmod_q <= '0;
			cquo_q <= '0;
			row_q  <= '0;
			rmod_q <= '0;
			rquo_q <= '0;
		end else if (acc) begin
			if (col_last) begin
				col_q  <= '0;
				cmod_q <= '0;
				cquo_q <= '0;
				if (row_last) begin
					row_q  <= '0;
					rmod_q <= '0;
					rquo_q <= '0;
				end else begin
					row_q <= row_q + ROW_W'(1);
					prz_q <= rmod_q == '0;
					prq_q <= rquo_q;
					if (rmod_q == f_last) begin
						rmod_q <= '0;
						rquo_q <= rquo_q + ROW_W'(1);
					end else begin
						rmod_q <= rmod_q + FCFG_W'(1);
					end
				end
			end else begin
				col_q <= col_q + COL_W'(1);
				pcz_q <= cmod_q == '0;
				pcq_q <= cquo_q;
				if (cmod_q == f_last) begin
					cmod_q <= '0;
					cquo_q <= cquo_q + COL_W'(1);
				end else begin
					cmod_q <= cmod_q + FCFG_W'(1);
				end
			end
		end
	end

	bxd_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_upper (
		.clk     (clk),
		.wr_en   (advance && s1_valid_q),
		.wr_addr (col_s1),
		.wr_data (mid_eff),
		.rd_en   (advance),
		.rd_addr (col_q),
		.rd_data (up_rd)
	);

	bxd_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_middle (
		.clk     (clk),
		.wr_en   (advance && s1_valid_q),
		.wr_addr (col_s1),
		.wr_data (pix_s1),
		.rd_en   (advance),
		.rd_addr (col_q),
		.rd_data (mid_rd)
	);

	// forward the write of the previous pixel when it hits the same column
	assign up_eff  = byp_s1 ? fup_s1 : up_rd;
	assign mid_eff = byp_s1 ? fmid_s1 : mid_rd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			cv_s1      <= '0;
			cv_s2      <= '0;
			win_q      <= '0;
		end else if (advance) begin
			s1_valid_q <= acc;
			cv_s1      <= acc ? cv : '0;
			cv_s2      <= cv_s1;
			if (s1_valid_q) begin
				win_q[0] <= win_q[1];
				win_q[1] <= win_q[2];
				win_q[2] <= {pix_s1, mid_eff, up_eff};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			pix_s1  <= {pix.pixel_red, pix.pixel_green, pix.pixel_blue};
			col_s1  <= col_q;
			byp_s1  <= s1_valid_q && (col_s1 == col_q);
			fup_s1  <= mid_eff;
			fmid_s1 <= pix_s1;
			for (int k = 0; k < LANES; k++) begin
				cand_s1[k] <= cand[k];
				cand_s2[k] <= cand_s1[k];
			end
		end
	end

	for (genvar k = 0; k < LANES; k++) begin : g_lane
		bxd_lane u_lane (
			.clk      (clk),
			.arst_n   (arst_n),
			.adv      (advance),
			.vld      (cv_s2[k]),
			.cand     (cand_s2[k]),
			.win      (win_q),
			.lane_out (lane_out[k])
		);
	end

	bxd_merge u_merge (
		.clk     (clk),
		.arst_n  (arst_n),
		.lane_in (lane_out),
		.adv     (lane_merge_adv),
		.res     (res)
	);

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		WEFF_W'(col_q) < w_eff && HEFF_W'(row_q) < h_eff)
		else $error("position counter outside the image");

	a_col_split: assert property (@(posedge clk) disable iff (!arst_n)
		cmod_q < f_eff && (cquo_q * COL_W'(f_eff) + COL_W'(cmod_q)) == col_q)
		else $error("column quotient and remainder disagree with column");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q && !advance |=> s1_valid_q && $stable(col_s1))
		else $error("stalled pixel left the line store stage");

endmodule

`default_nettype wire
